>>> sv/lwci_pkg.sv
// Shared types and constants for the linear window to colour index mapper.
`timescale 1ns / 1ps

package lwci_pkg;

  // APB register map: four 32-bit registers at byte offsets 0, 4, 8 and 12
  localparam int unsigned CfgAddrWidth = 4;
  localparam int unsigned CfgDataWidth = 32;

  typedef enum logic [1:0] {
    RegWindowLow  = 2'd0,
    RegWindowHigh = 2'd1,
    RegTableSize  = 2'd2,
    RegInvertMode = 2'd3
  } lwci_reg_e;

  // Register reset values
  localparam int ResetWindowLow  = 0;
  localparam int ResetWindowHigh = 256;
  localparam int ResetTableSize  = 256;

  // Window classification of a sample, carried alongside the datapath
  typedef struct packed {
    logic below;
    logic above;
  } lwci_flags_t;

endpackage

>>> sv/lwci_cfg.sv
// APB register file with pre-computed window width and top index.
`timescale 1ns / 1ps

module lwci_cfg #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned INDEX_WIDTH  = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lwci_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [lwci_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [lwci_pkg::CfgDataWidth-1:0]  prdata,
  output logic                               pready,
  output logic [SAMPLE_WIDTH-1:0]            win_low_o,
  output logic [SAMPLE_WIDTH-1:0]            win_high_o,
  output logic [INDEX_WIDTH-1:0]             top_o,
  output logic [SAMPLE_WIDTH-1:0]            den_o,
  output logic                               invert_o
);
  import lwci_pkg::*;

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned IW = INDEX_WIDTH;

  // Window width, zero forced to one; only meaningful for low <= high
  function automatic logic [SW-1:0] calc_den(logic [SW-1:0] lo, logic [SW-1:0] hi);
    logic [SW:0] diff;
    diff = {hi[SW-1], hi} - {lo[SW-1], lo};
    if (diff[SW-1:0] == '0) begin
      return {{(SW-1){1'b0}}, 1'b1};
    end
    return diff[SW-1:0];
  endfunction

  // Top index: size zero taken as one, size above 2^IW saturated
  function automatic logic [IW-1:0] calc_top(logic [IW:0] size);
    if (size == '0) begin
      return '0;
    end else if (size[IW]) begin
      return '1;
    end
    return size[IW-1:0] - {{(IW-1){1'b0}}, 1'b1};
  endfunction

  logic [SW-1:0] low_q, low_d;
  logic [SW-1:0] high_q, high_d;
  logic [IW:0]   size_q, size_d;
  logic          invert_q, invert_d;
  logic [SW-1:0] den_q;
  logic [IW-1:0] top_q;
  logic          wr_en;
  lwci_reg_e     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = lwci_reg_e'(paddr[CfgAddrWidth-1:2]);

  // Next register values
  always_comb begin
    low_d    = low_q;
    high_d   = high_q;
    size_d   = size_q;
    invert_d = invert_q;
    if (wr_en) begin
      case (reg_sel)
        RegWindowLow:  low_d    = pwdata[SW-1:0];
        RegWindowHigh: high_d   = pwdata[SW-1:0];
        RegTableSize:  size_d   = pwdata[IW:0];
        RegInvertMode: invert_d = pwdata[0];
        default: ;
      endcase
    end
  end

  // Registers, derived values updated on the same edge as the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= SW'(ResetWindowLow);
      high_q   <= SW'(ResetWindowHigh);
      size_q   <= (IW + 1)'(ResetTableSize);
      invert_q <= 1'b0;
      den_q    <= calc_den(SW'(ResetWindowLow), SW'(ResetWindowHigh));
      top_q    <= calc_top((IW + 1)'(ResetTableSize));
    end else begin
      low_q    <= low_d;
      high_q   <= high_d;
      size_q   <= size_d;
      invert_q <= invert_d;
      den_q    <= calc_den(low_d, high_d);
      top_q    <= calc_top(size_d);
    end
  end

  // Read-back
  always_comb begin
    case (reg_sel)
      RegWindowLow:  prdata = CfgDataWidth'(low_q);
      RegWindowHigh: prdata = CfgDataWidth'(high_q);
      RegTableSize:  prdata = CfgDataWidth'(size_q);
      RegInvertMode: prdata = CfgDataWidth'(invert_q);
      default:       prdata = '0;
    endcase
  end

  assign win_low_o  = low_q;
  assign win_high_o = high_q;
  assign top_o      = top_q;
  assign den_o      = den_q;
  assign invert_o   = invert_q;

endmodule

>>> sv/lwci_front.sv
// Front stages: window compare and offset, then scaling by the top index.
`timescale 1ns / 1ps

module lwci_front #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned INDEX_WIDTH  = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic [SAMPLE_WIDTH-1:0]               sample_i,
  input  logic [SAMPLE_WIDTH-1:0]               win_low_i,
  input  logic [SAMPLE_WIDTH-1:0]               win_high_i,
  input  logic [INDEX_WIDTH-1:0]                top_i,
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output lwci_pkg::lwci_flags_t                 flags_o,
  output logic [SAMPLE_WIDTH+INDEX_WIDTH-1:0]   prod_o
);
  import lwci_pkg::*;

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned PW = SAMPLE_WIDTH + INDEX_WIDTH;

  logic          a_valid_q;
  lwci_flags_t   a_flags_q, a_flags_d;
  logic [SW-1:0] a_num_q, a_num_d;
  logic          a_stall;
  logic          b_valid_q;
  lwci_flags_t   b_flags_q;
  logic [PW-1:0] b_prod_q, b_prod_d;
  logic          b_stall;

  // A stage holds its beat only when it is full and the next stage is stuck
  assign b_stall = b_valid_q & stall_i;
  assign a_stall = a_valid_q & b_stall;
  assign stall_o = a_stall;

  // Stage A: classify against the window, offset from the low bound.
  // Inside the window the offset fits SAMPLE_WIDTH bits unsigned.
  always_comb begin
    a_flags_d.below = $signed(sample_i) < $signed(win_low_i);
    a_flags_d.above = $signed(sample_i) > $signed(win_high_i);
    a_num_d         = sample_i - win_low_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (!a_stall) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !a_stall) begin
      a_flags_q <= a_flags_d;
      a_num_q   <= a_num_d;
    end
  end

  // Stage B: offset times top index
  assign b_prod_d = PW'(a_num_q) * PW'(top_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (!b_stall) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && !b_stall) begin
      b_flags_q <= a_flags_q;
      b_prod_q  <= b_prod_d;
    end
  end

  assign valid_o = b_valid_q;
  assign flags_o = b_flags_q;
  assign prod_o  = b_prod_q;

endmodule

>>> sv/lwci_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module lwci_div #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned INDEX_WIDTH  = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  lwci_pkg::lwci_flags_t                 flags_i,
  input  logic [SAMPLE_WIDTH+INDEX_WIDTH-1:0]   prod_i,
  input  logic [SAMPLE_WIDTH-1:0]               den_i,
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output lwci_pkg::lwci_flags_t                 flags_o,
  output logic [INDEX_WIDTH-1:0]                quo_o
);
  import lwci_pkg::*;

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned IW = INDEX_WIDTH;

  // The quotient is at most the top index, so the upper product bits start
  // below the divisor and each stage brings down one lower bit.
  logic          vld_q  [IW];
  logic [SW-1:0] rem_q  [IW];
  logic [IW-1:0] lo_q   [IW];
  logic [IW-1:0] quo_q  [IW];
  lwci_flags_t   flg_q  [IW];
  logic          stl    [IW];

  for (genvar i = 0; i < IW; i++) begin : g_stage
    logic          in_vld;
    logic [SW-1:0] in_rem;
    logic [IW-1:0] in_lo;
    logic [IW-1:0] in_quo;
    lwci_flags_t   in_flg;
    logic          dn_stall;
    logic [SW:0]   trial;
    logic [SW:0]   diff;
    logic          take;

    if (i == 0) begin : g_first
      assign in_vld = valid_i;
      assign in_rem = prod_i[SW+IW-1:IW];
      assign in_lo  = prod_i[IW-1:0];
      assign in_quo = '0;
      assign in_flg = flags_i;
    end else begin : g_next
      assign in_vld = vld_q[i-1];
      assign in_rem = rem_q[i-1];
      assign in_lo  = lo_q[i-1];
      assign in_quo = quo_q[i-1];
      assign in_flg = flg_q[i-1];
    end

    if (i == IW - 1) begin : g_last
      assign dn_stall = stall_i;
    end else begin : g_mid
      assign dn_stall = stl[i+1];
    end

    assign stl[i] = vld_q[i] & dn_stall;

    // Trial subtract of the divisor from the shifted remainder
    assign trial = {in_rem, in_lo[IW-1]};
    assign diff  = trial - {1'b0, den_i};
    assign take  = trial >= {1'b0, den_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (!stl[i]) begin
        vld_q[i] <= in_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (in_vld && !stl[i]) begin
        rem_q[i] <= take ? diff[SW-1:0] : trial[SW-1:0];
        lo_q[i]  <= {in_lo[IW-2:0], 1'b0};
        quo_q[i] <= {in_quo[IW-2:0], take};
        flg_q[i] <= in_flg;
      end
    end
  end

  assign stall_o = stl[0];
  assign valid_o = vld_q[IW-1];
  assign flags_o = flg_q[IW-1];
  assign quo_o   = quo_q[IW-1];

endmodule

>>> sv/linear_window_to_color_index.sv
// Linear window to colour table index mapper, top level.
// Stages from input beat to output beat:
//   window compare, multiply, one divider stage per quotient bit, output register.
// Throughput: one beat per cycle while the output is not stalled; stages fill bubbles independently under stall.
// Reset: clears every valid bit and loads the registers with their reset values.
`timescale 1ns / 1ps

module linear_window_to_color_index #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned INDEX_WIDTH  = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lwci_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [lwci_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [lwci_pkg::CfgDataWidth-1:0]  prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0]            sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [INDEX_WIDTH-1:0]             color_index_o
);
  import lwci_pkg::*;

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned IW = INDEX_WIDTH;
  localparam int unsigned PW = SAMPLE_WIDTH + INDEX_WIDTH;

  logic [SW-1:0] win_low;
  logic [SW-1:0] win_high;
  logic [IW-1:0] top;
  logic [SW-1:0] den;
  logic          invert;

  logic          fr_valid;
  logic          fr_stall;
  lwci_flags_t   fr_flags;
  logic [PW-1:0] fr_prod;

  logic          dv_valid;
  logic          dv_stall;
  lwci_flags_t   dv_flags;
  logic [IW-1:0] dv_quo;

  logic          out_valid_q;
  logic [IW-1:0] color_index_q, color_index_d;
  logic [IW-1:0] idx_sel;

  lwci_cfg #(
    .SAMPLE_WIDTH (SW),
    .INDEX_WIDTH  (IW)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .win_low_o  (win_low),
    .win_high_o (win_high),
    .top_o      (top),
    .den_o      (den),
    .invert_o   (invert)
  );

  lwci_front #(
    .SAMPLE_WIDTH (SW),
    .INDEX_WIDTH  (IW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .stall_o    (in_stall_o),
    .sample_i   (sample_i),
    .win_low_i  (win_low),
    .win_high_i (win_high),
    .top_i      (top),
    .valid_o    (fr_valid),
    .stall_i    (fr_stall),
    .flags_o    (fr_flags),
    .prod_o     (fr_prod)
  );

  lwci_div #(
    .SAMPLE_WIDTH (SW),
    .INDEX_WIDTH  (IW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .stall_o (fr_stall),
    .flags_i (fr_flags),
    .prod_i  (fr_prod),
    .den_i   (den),
    .valid_o (dv_valid),
    .stall_i (dv_stall),
    .flags_o (dv_flags),
    .quo_o   (dv_quo)
  );

  // Output register: clamp outside the window, then optional mirror
  assign dv_stall = out_valid_q & out_stall_i;

  always_comb begin
    if (dv_flags.below) begin
      idx_sel = '0;
    end else if (dv_flags.above) begin
      idx_sel = top;
    end else begin
      idx_sel = dv_quo;
    end
    color_index_d = invert ? (top - idx_sel) : idx_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!dv_stall) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_valid && !dv_stall) begin
      color_index_q <= color_index_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign color_index_o = color_index_q;

  // Checks
  a_index_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (color_index_o <= top))
    else $error("colour index beyond top of table");

  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    den != '0)
    else $error("window width divisor is zero");

endmodule
